// File: hw/rtl/gck_pkg.sv
// Shared types and constants of the chord key mapper.
`default_nettype none

package gck_pkg;

  localparam int unsigned PinCount = 16;
  localparam int unsigned LidPin   = 10;

  localparam logic [15:0] LidBit  = 16'h0400;
  localparam logic [15:0] PinMask = 16'((33'd1 << PinCount) - 33'd1);
  localparam logic [15:0] MaskRst = 16'h0400;

  // table entry kinds
  localparam logic [1:0] KindEmpty = 2'd0;
  localparam logic [1:0] KindKey   = 2'd1;
  localparam logic [1:0] KindCmd   = 2'd2;

  // event kinds
  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvPress    = 3'd1;
  localparam logic [2:0] EvRelease  = 3'd2;
  localparam logic [2:0] EvCmd      = 3'd3;
  localparam logic [2:0] EvShutdown = 3'd4;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpQuiet = 2'd1,
    OpWalk  = 2'd2
  } op_e;

  // classified word handed from front to back
  typedef struct packed {
    op_e         op;
    logic        shutdown;
    logic [3:0]  slot;
    logic [15:0] pins;
    logic [1:0]  kind;
    logic [9:0]  code;
    logic [15:0] levels;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pins;
    logic [1:0]  kind;
    logic [9:0]  code;
  } entry_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] code;
    logic [3:0] slot;
    logic       last;
  } evt_t;

endpackage

`default_nettype wire

// File: hw/rtl/gck_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gck_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gck_front.sv
// Front end: config register, sample masking, change detection, classification.
`default_nettype none

module gck_front import gck_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [3:0]  entry_slot_i,
  input  wire logic [15:0] entry_pins_i,
  input  wire logic [1:0]  entry_kind_i,
  input  wire logic [9:0]  entry_code_i,
  input  wire logic [15:0] pin_levels_i,
  input  wire logic [15:0] pin_interrupts_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output cmd_t             q_cmd_o
);

  logic [15:0] mask_q;
  logic [15:0] prev_q, prev_d;
  logic [15:0] mon, levels, irq;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;
  assign q_push_o    = accept;

  always_comb begin
    mon    = mask_q | LidBit;
    levels = (pin_levels_i & mon) ^ LidBit;   // lid switch is active low
    irq    = (pin_interrupts_i & mon) | ((levels ^ prev_q) & PinMask);
    prev_d = (accept && mode_i) ? levels : prev_q;

    q_cmd_o.op       = !mode_i ? OpWrite : ((irq == '0) ? OpQuiet : OpWalk);
    q_cmd_o.shutdown = irq[LidPin];
    q_cmd_o.slot     = entry_slot_i;
    q_cmd_o.pins     = entry_pins_i;
    q_cmd_o.kind     = entry_kind_i;
    q_cmd_o.code     = entry_code_i;
    q_cmd_o.levels   = levels;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskRst;
      prev_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        mask_q <= cfg_wdata_i;
      end
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gck_queue.sv
// Two-entry queue of classified words between front and back.
`default_nettype none

module gck_queue import gck_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o,
  input  wire logic pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gck_back.sv
// Back end: table storage, chord walk, event holding and output register.
`default_nettype none

module gck_back import gck_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output evt_t      out_evt_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StFinish
  } state_e;

  state_e                   state_q, state_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [15:0]              work_q, work_d;
  logic [TABLE_ENTRIES-1:0] active_q, active_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  evt_t                     pend_q;
  logic                     pend_valid_q;
  logic                     out_valid_q;
  evt_t                     out_evt_q;

  logic             out_free, can_push, push, move, set_last;
  evt_t             push_evt;
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  waddr, raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t           wentry, entry;
  logic [1:0]       e_kind;
  logic             live, match, act, need_push, in_range;

  gck_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign can_push    = !pend_valid_q || out_free;
  assign move        = pend_valid_q && out_free && (pend_q.last || push);
  assign out_valid_o = out_valid_q;
  assign out_evt_o   = out_evt_q;

  assign waddr       = IdxW'(q_cmd_i.slot);
  assign wentry.pins = q_cmd_i.pins;
  assign wentry.kind = q_cmd_i.kind;
  assign wentry.code = q_cmd_i.code;
  assign in_range    = {28'd0, q_cmd_i.slot} < 32'(TABLE_ENTRIES);

  // never-written entries read as empty
  assign entry     = entry_t'(ram_rdata);
  assign e_kind    = valid_q[idx_q] ? entry.kind : KindEmpty;
  assign live      = (e_kind == KindKey) || (e_kind == KindCmd);
  assign match     = live && ((entry.pins & work_q) == entry.pins);
  assign act       = active_q[idx_q];
  assign need_push = (match && !act) || (!match && act && (e_kind == KindKey));

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    work_d   = work_q;
    active_d = active_q;
    valid_d  = valid_q;
    q_pop_o  = 1'b0;
    push     = 1'b0;
    push_evt = '0;
    set_last = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    raddr    = idx_q;

    unique case (state_q)
      StIdle: begin
        if (q_valid_i && can_push) begin
          q_pop_o = 1'b1;
          unique case (q_cmd_i.op)
            OpWrite: begin
              if (in_range) begin
                ram_we          = 1'b1;
                valid_d[waddr]  = 1'b1;
                active_d[waddr] = 1'b0;
              end
              push          = 1'b1;
              push_evt.kind = EvNone;
              push_evt.slot = q_cmd_i.slot;
              push_evt.last = 1'b1;
            end
            OpQuiet: begin
              push          = 1'b1;
              push_evt.kind = EvNone;
              push_evt.last = 1'b1;
            end
            OpWalk: begin
              push          = q_cmd_i.shutdown;
              push_evt.kind = EvShutdown;
              work_d        = q_cmd_i.levels;
              idx_d         = '0;
              ram_re        = 1'b1;
              raddr         = '0;
              state_d       = StEval;
            end
            default: ;
          endcase
        end
      end
      StEval: begin
        // hold the entry read while the event holder is blocked
        if (!need_push || can_push) begin
          push_evt.code = entry.code;
          push_evt.slot = 4'(idx_q);
          if (match) begin
            active_d[idx_q] = 1'b1;
            work_d          = work_q & ~entry.pins;
            push            = !act;
            push_evt.kind   = (e_kind == KindKey) ? EvPress : EvCmd;
          end else if (act) begin
            active_d[idx_q] = 1'b0;
            push            = (e_kind == KindKey);
            push_evt.kind   = EvRelease;
          end
          if (idx_q == LastIdx) begin
            state_d = StFinish;
          end else begin
            idx_d  = idx_q + IdxW'(1);
            ram_re = 1'b1;
            raddr  = idx_q + IdxW'(1);
          end
        end
      end
      StFinish: begin
        if (pend_valid_q) begin
          set_last = 1'b1;
        end else begin
          push          = 1'b1;
          push_evt.kind = EvNone;
          push_evt.last = 1'b1;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      work_q       <= '0;
      active_q     <= '0;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_evt_q    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      work_q   <= work_d;
      active_q <= active_d;
      valid_q  <= valid_d;
      // last flag is only known once a later event or the walk end shows up
      if (push) begin
        pend_valid_q <= 1'b1;
        pend_q       <= push_evt;
      end else if (move) begin
        pend_valid_q <= 1'b0;
      end else if (set_last) begin
        pend_q.last <= 1'b1;
      end
      if (out_free) begin
        out_valid_q <= move;
        if (move) begin
          out_evt_q <= pend_q;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gpio_chord_key_mapper.sv
// Top level of the GPIO chord key mapper.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------------------
//   cfg     | cfg_valid_i / cfg_ready_o  | cfg_wdata_i (monitored pin mask)
//   in      | in_valid_i / in_stall_o    | mode, entry_*, pin_levels, pin_interrupts
//   out     | out_valid_o / out_stall_i  | event_kind, event_code, event_slot, last
//
// A table write or a quiet sample is handled in the back end as it is popped. A
// sample that walks the table goes through a pop, one evaluation per entry
// through the registered table read, and then a closing step.
// The front takes a word per cycle while the 2-entry queue has room.
// Output stalls hold the walk only when a new event has nowhere to go.
// Reset empties the table (per-entry valid bits), clears flags and queue.
`default_nettype none

module gpio_chord_key_mapper import gck_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [3:0]  entry_slot_i,
  input  wire logic [15:0] entry_pins_i,
  input  wire logic [1:0]  entry_kind_i,
  input  wire logic [9:0]  entry_code_i,
  input  wire logic [15:0] pin_levels_i,
  input  wire logic [15:0] pin_interrupts_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_kind_o,
  output logic [9:0]       event_code_o,
  output logic [3:0]       event_slot_o,
  output logic             last_event_o
);

  logic q_full, q_push, q_valid, q_pop;
  cmd_t q_cmd_in, q_cmd_out;
  evt_t evt;

  gck_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .entry_slot_i    (entry_slot_i),
    .entry_pins_i    (entry_pins_i),
    .entry_kind_i    (entry_kind_i),
    .entry_code_i    (entry_code_i),
    .pin_levels_i    (pin_levels_i),
    .pin_interrupts_i(pin_interrupts_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd_in)
  );

  gck_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .cmd_o  (q_cmd_out),
    .pop_i  (q_pop)
  );

  gck_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_evt_o  (evt)
  );

  assign event_kind_o = evt.kind;
  assign event_code_o = evt.code;
  assign event_slot_o = evt.slot;
  assign last_event_o = evt.last;

endmodule

`default_nettype wire

// File: bench/gck_event_checker.sv
// Bench codes and the event checker of the chord key mapper.
`timescale 1ns / 1ps

package gck_tb_pkg;

  localparam logic       ModeWrite  = 1'b0;
  localparam logic       ModeSample = 1'b1;
  // kind three: stored, but never walked
  localparam logic [1:0] KindSpare  = 2'd3;
  localparam int         TableSlots = 16;

endpackage

module gck_event_checker import gck_pkg::*; import gck_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic [3:0]  entry_slot_i,
  input  logic [15:0] entry_pins_i,
  input  logic [1:0]  entry_kind_i,
  input  logic [9:0]  entry_code_i,
  input  logic [15:0] pin_levels_i,
  input  logic [15:0] pin_interrupts_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  event_kind_i,
  input  logic [9:0]  event_code_i,
  input  logic [3:0]  event_slot_i,
  input  logic        last_event_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  logic [15:0] watch_mask;
  logic [15:0] prev_levels;
  entry_t      chord_tbl [TableSlots];
  logic [TableSlots-1:0] chord_active;
  evt_t        expected_events [$];
  evt_t        staged;
  bit          staged_ok;

  // hold one event back so the final one of a word can carry the last flag
  task automatic stage_event(input logic [2:0] kind, input logic [9:0] code,
                             input logic [3:0] slot);
    if (staged_ok) expected_events.push_back(staged);
    staged    = '{kind, code, slot, 1'b0};
    staged_ok = 1'b1;
  endtask

  task automatic map_word(input logic mode, input logic [3:0] slot,
                          input logic [15:0] pins, input logic [1:0] kind,
                          input logic [9:0] code, input logic [15:0] lv_raw,
                          input logic [15:0] irq_raw);
    logic [15:0] mon;
    logic [15:0] lv;
    logic [15:0] irq;
    logic [15:0] work;
    if (mode == ModeWrite) begin
      chord_tbl[slot]    = '{pins, kind, code};
      chord_active[slot] = 1'b0;
      stage_event(EvNone, '0, slot);
    end else begin
      mon = watch_mask | LidBit;
      lv  = (lv_raw & mon) ^ LidBit;
      // changed pins without an interrupt get one
      irq = (irq_raw & mon) | ((lv ^ prev_levels) & PinMask);
      prev_levels = lv;
      if (irq != '0) begin
        if ((irq & LidBit) != '0) stage_event(EvShutdown, '0, '0);
        work = lv;
        for (int i = 0; i < TableSlots; i++) begin
          if (chord_tbl[i].kind == KindKey || chord_tbl[i].kind == KindCmd) begin
            if ((chord_tbl[i].pins & work) == chord_tbl[i].pins) begin
              if (!chord_active[i]) begin
                chord_active[i] = 1'b1;
                stage_event((chord_tbl[i].kind == KindKey) ? EvPress : EvCmd,
                            chord_tbl[i].code, 4'(i));
              end
              work &= ~chord_tbl[i].pins;
            end else if (chord_active[i]) begin
              chord_active[i] = 1'b0;
              if (chord_tbl[i].kind == KindKey)
                stage_event(EvRelease, chord_tbl[i].code, 4'(i));
            end
          end
        end
      end
      if (!staged_ok) stage_event(EvNone, '0, '0);
    end
    staged.last = 1'b1;
    expected_events.push_back(staged);
    staged_ok = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    evt_t want;
    if (!rst_ni) begin
      watch_mask   = MaskRst;
      prev_levels  = '0;
      for (int i = 0; i < TableSlots; i++) chord_tbl[i] = '0;
      chord_active = '0;
      expected_events.delete();
      staged_ok    = 1'b0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // a result never belongs to a word taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected event kind %0d code %0d slot %0d last %0d",
                     $realtime, event_kind_i, event_code_i, event_slot_i, last_event_i);
          fail_count_o++;
        end else begin
          want = expected_events.pop_front();
          checked_o++;
          if (event_kind_i !== want.kind || event_code_i !== want.code ||
              event_slot_i !== want.slot || last_event_i !== want.last) begin
            if (fail_count_o < 10)
              $display("%0t: event mismatch: expected kind %0d code %0d slot %0d last %0d, %s",
                       $realtime, want.kind, want.code, want.slot, want.last,
                       $sformatf("got kind %0d code %0d slot %0d last %0d",
                                 event_kind_i, event_code_i, event_slot_i,
                                 last_event_i));
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        map_word(mode_i, entry_slot_i, entry_pins_i, entry_kind_i, entry_code_i,
                 pin_levels_i, pin_interrupts_i);
      if (cfg_valid_i && cfg_ready_i) watch_mask = cfg_wdata_i;
    end
    pending_o = expected_events.size();
  end

endmodule

// File: bench/tb_gpio_chord_key_mapper.sv
// Stimulus and verdict for the chord key mapper bench.
`timescale 1ns / 1ps

module tb_gpio_chord_key_mapper import gck_pkg::*; import gck_tb_pkg::*;;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_wdata      = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        mode           = ModeWrite;
  logic [3:0]  entry_slot     = '0;
  logic [15:0] entry_pins     = '0;
  logic [1:0]  entry_kind     = KindEmpty;
  logic [9:0]  entry_code     = '0;
  logic [15:0] pin_levels     = '0;
  logic [15:0] pin_interrupts = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [2:0]  event_kind;
  logic [9:0]  event_code;
  logic [3:0]  event_slot;
  logic        last_event;

  int fails;
  int pending;
  int checked;
  int table_writes = 0;
  int samples      = 0;
  int mask_writes  = 0;
  bit calm         = 1'b0;
  logic [15:0] shadow_pins [TableSlots];

  gpio_chord_key_mapper dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (mode),
    .entry_slot_i     (entry_slot),
    .entry_pins_i     (entry_pins),
    .entry_kind_i     (entry_kind),
    .entry_code_i     (entry_code),
    .pin_levels_i     (pin_levels),
    .pin_interrupts_i (pin_interrupts),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .event_kind_o     (event_kind),
    .event_code_o     (event_code),
    .event_slot_o     (event_slot),
    .last_event_o     (last_event)
  );

  gck_event_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .mode_i           (mode),
    .entry_slot_i     (entry_slot),
    .entry_pins_i     (entry_pins),
    .entry_kind_i     (entry_kind),
    .entry_code_i     (entry_code),
    .pin_levels_i     (pin_levels),
    .pin_interrupts_i (pin_interrupts),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .event_kind_i     (event_kind),
    .event_code_i     (event_code),
    .event_slot_i     (event_slot),
    .last_event_i     (last_event),
    .fail_count_o     (fails),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall = !calm && ($urandom_range(99) < 26);
  end

  task automatic send_word(input logic m, input logic [3:0] s, input logic [15:0] p,
                           input logic [1:0] k, input logic [9:0] c,
                           input logic [15:0] lv, input logic [15:0] iq);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 26) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 26);
    end
    mode           = m;
    entry_slot     = s;
    entry_pins     = p;
    entry_kind     = k;
    entry_code     = c;
    pin_levels     = lv;
    pin_interrupts = iq;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    if (m == ModeWrite) begin
      shadow_pins[s] = p;
      table_writes++;
    end else begin
      samples++;
    end
  endtask

  // mask changes only with the block drained
  task automatic set_mask(input logic [15:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    cfg_wdata = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    mask_writes++;
  endtask

  initial begin
    logic [15:0] lv;
    logic [15:0] iq;
    logic [15:0] p;
    logic        lid_raw;
    int          pick;
    for (int s = 0; s < TableSlots; s++) shadow_pins[s] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset mask: lid pin only
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h0400, 16'h0000);
    send_word(ModeSample, 4'd9, 16'hFFFF, KindSpare, 10'h3FF, 16'hFFFF, 16'hFFFF);
    set_mask(16'hFFFF);
    send_word(ModeWrite, 4'd0,  16'h0003, KindKey,   10'h3FF, 16'h0000, 16'h0000);
    send_word(ModeWrite, 4'd1,  16'h0000, KindCmd,   10'h000, 16'hFFFF, 16'hFFFF);
    send_word(ModeWrite, 4'd2,  16'hFFFF, KindKey,   10'h155, 16'h0000, 16'h0000);
    send_word(ModeWrite, 4'd3,  16'h0004, KindSpare, 10'h2AA, 16'h0000, 16'h0000);
    send_word(ModeWrite, 4'd15, 16'h0008, KindEmpty, 10'h001, 16'h0000, 16'h0000);
    send_word(ModeWrite, 4'd14, 16'h0008, KindKey,   10'h200, 16'h0000, 16'h0000);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h0403, 16'h0003);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h0403, 16'h0000);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h0403, 16'h0001);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h040F, 16'h0000);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h0400, 16'h0000);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'hFBFF, 16'h0000);
    // rewrite while active clears the flag
    send_word(ModeWrite, 4'd0,  16'h0003, KindKey,   10'h3FF, 16'h0000, 16'h0000);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'hFFFF, 16'h8000);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h0000, 16'hFFFF);
    send_word(ModeWrite, 4'd2,  16'h0400, KindKey,   10'h0AB, 16'h0000, 16'h0000);
    send_word(ModeSample, 4'd0, 16'h0000, KindEmpty, 10'd0, 16'h0000, 16'h0000);

    lid_raw = 1'b0;
    for (int n = 0; n < 420; n++) begin
      if (n == 140) set_mask(16'h0000);
      if (n == 200) set_mask(16'($urandom));
      if (n == 360) set_mask(16'hFFFF);
      calm = (n >= 220 && n < 300);
      if ($urandom_range(99) < 15) begin
        pick = $urandom_range(9);
        if (pick == 0) p = '0;
        else if (pick == 1) p = 16'($urandom);
        else begin
          p = 16'(1) << $urandom_range(15);
          repeat ($urandom_range(2)) p |= 16'(1) << $urandom_range(15);
        end
        send_word(ModeWrite, 4'($urandom_range(15)), p, 2'($urandom_range(3)),
                  10'($urandom_range(1023)), 16'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(99) < 10) lid_raw = ~lid_raw;
        if ($urandom_range(3) == 0) begin
          lv = 16'($urandom);
        end else begin
          // chords built from what the table holds
          lv = '0;
          for (int s = 0; s < TableSlots; s++)
            if ($urandom_range(9) < 3) lv |= shadow_pins[s];
          if ($urandom_range(3) == 0) lv |= 16'(1) << $urandom_range(15);
          lv[LidPin] = lid_raw;
        end
        pick = $urandom_range(9);
        if (pick < 5) iq = '0;
        else if (pick < 8) iq = 16'(1) << $urandom_range(15);
        else iq = 16'($urandom);
        send_word(ModeSample, 4'($urandom_range(15)), 16'($urandom),
                  2'($urandom_range(3)), 10'($urandom_range(1023)), lv, iq);
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("%0d words sent: %0d table writes, %0d pin samples, over %0d mask settings",
             table_writes + samples, table_writes, samples, mask_writes + 1);
    $display("%0d events checked, %0d failures, %0d events still outstanding",
             checked, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
